// ===== rtl/pats_pkg.sv =====
// Shared types, constants and helpers of the priority aging task scheduler.
package pats_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int CMD_W         = 2;
    localparam int TASK_W        = 4;
    localparam int PRIO_W        = 6;
    localparam int COUNT_W       = 5;
    localparam int TASK_SPAN     = 1 << TASK_W;

    typedef logic [CMD_W-1:0]         t_cmd;
    typedef logic [TASK_W-1:0]        t_task;
    typedef logic signed [PRIO_W-1:0] t_prio;

    localparam t_cmd CMD_SET_PRIO = 2'd0;
    localparam t_cmd CMD_ENQUEUE  = 2'd1;
    localparam t_cmd CMD_PICK     = 2'd2;

    localparam t_prio PRIO_MIN = -6'sd20;
    localparam t_prio PRIO_MAX = 6'sd20;

    typedef struct packed {
        logic eval;
        logic pick;
        logic age;
        logic load;
        logic set;
    } t_queue_ctrl;

    typedef struct packed {
        logic set_en;
        logic enq_en;
        logic pick_en;
    } t_table_ctrl;

    function automatic t_prio age_prio(input t_prio p);
        t_prio r;
        r = (p > PRIO_MIN) ? t_prio'(p - 6'sd1) : p;
        return r;
    endfunction

endpackage

// ===== rtl/pats_cell.sv =====
// One ready-queue slot: task number, dynamic priority and registered win flag.
module pats_cell import pats_pkg::*; #(
    parameter int N        = MAX_TASKS_DEF,
    parameter int CELL_IDX = 0,
    parameter int LEN_W    = $clog2(MAX_TASKS_DEF + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_queue_ctrl       i_ctrl,
    input  logic [LEN_W-1:0]  i_len,
    input  t_task             i_task,
    input  t_prio             i_prio,
    input  t_prio             i_prio_all [N],
    input  logic [N-1:0]      i_win_all,
    input  t_task             i_next_task,
    input  t_prio             i_next_prio,
    output t_task             o_task,
    output t_prio             o_prio,
    output t_prio             o_prio_aged,
    output logic              o_win
);

    t_task r_task, n_task;
    t_prio r_prio, n_prio;
    logic  r_win, n_win;
    logic  w_occ;
    logic  w_beaten;
    logic  w_shift;
    t_prio w_aged;

    assign w_occ  = int'(i_len) > CELL_IDX;
    assign w_aged = i_ctrl.age ? age_prio(r_prio) : r_prio;

    always_comb begin
        w_beaten = 1'b0;
        for (int j = 0; j < N; j++) begin
            if (int'(i_len) > j) begin
                if (j < CELL_IDX && i_prio_all[j] <= r_prio) begin
                    w_beaten = 1'b1;
                end
                if (j > CELL_IDX && i_prio_all[j] < r_prio) begin
                    w_beaten = 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_shift = 1'b0;
        for (int j = 0; j <= CELL_IDX; j++) begin
            w_shift = w_shift | i_win_all[j];
        end
    end

    always_comb begin
        n_task = r_task;
        n_prio = r_prio;
        n_win  = r_win;
        if (i_ctrl.eval) begin
            n_win = w_occ && !w_beaten;
        end
        if (i_ctrl.pick) begin
            if (w_shift) begin
                n_task = i_next_task;
                n_prio = i_next_prio;
            end else begin
                n_prio = w_aged;
            end
        end
        if (i_ctrl.load && int'(i_len) == CELL_IDX) begin
            n_task = i_task;
            n_prio = i_prio;
        end
        if (i_ctrl.set && w_occ && r_task == i_task) begin
            n_prio = i_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_task <= n_task;
        r_prio <= n_prio;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= 1'b0;
        end else begin
            r_win <= n_win;
        end
    end

    assign o_task      = r_task;
    assign o_prio      = r_prio;
    assign o_prio_aged = w_aged;
    assign o_win       = r_win;

endmodule

// ===== rtl/pats_queue.sv =====
// Ready queue as a chain of slot cells; removal shifts each cell from its neighbor.
module pats_queue import pats_pkg::*; #(
    parameter int N     = MAX_TASKS_DEF,
    parameter int LEN_W = $clog2(MAX_TASKS_DEF + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_queue_ctrl      i_ctrl,
    input  logic [LEN_W-1:0] i_len,
    input  t_task            i_task,
    input  t_prio            i_prio,
    output logic [N-1:0]     o_win,
    output t_task            o_win_task
);

    t_task w_task [N];
    t_prio w_prio [N];
    t_prio w_aged [N];
    t_task w_next_task [N];
    t_prio w_next_prio [N];

    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == N - 1) begin : g_last
            assign w_next_task[g] = w_task[g];
            assign w_next_prio[g] = w_prio[g];
        end else begin : g_mid
            assign w_next_task[g] = w_task[g+1];
            assign w_next_prio[g] = w_aged[g+1];
        end

        pats_cell #(
            .N        (N),
            .CELL_IDX (g),
            .LEN_W    (LEN_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (i_ctrl),
            .i_len       (i_len),
            .i_task      (i_task),
            .i_prio      (i_prio),
            .i_prio_all  (w_prio),
            .i_win_all   (o_win),
            .i_next_task (w_next_task[g]),
            .i_next_prio (w_next_prio[g]),
            .o_task      (w_task[g]),
            .o_prio      (w_prio[g]),
            .o_prio_aged (w_aged[g]),
            .o_win       (o_win[g])
        );
    end

    always_comb begin
        o_win_task = '0;
        for (int i = 0; i < N; i++) begin
            if (o_win[i]) begin
                o_win_task = o_win_task | w_task[i];
            end
        end
    end

endmodule

// ===== rtl/pats_task_table.sv =====
// Per-task static priority, idle dynamic priority and queued flag.
module pats_task_table import pats_pkg::*; #(
    parameter int DEPTH  = MAX_TASKS_DEF,
    parameter int IDX_W  = $clog2(MAX_TASKS_DEF)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_table_ctrl      i_ctrl,
    input  logic [IDX_W-1:0] i_idx,
    input  t_prio            i_prio,
    input  logic [IDX_W-1:0] i_pick_idx,
    output t_prio            o_dyn,
    output logic             o_queued
);

    t_prio r_static [DEPTH];
    t_prio r_dyn    [DEPTH];
    logic  r_queued [DEPTH];

    assign o_dyn    = r_dyn[i_idx];
    assign o_queued = r_queued[i_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_static[i] <= '0;
                r_dyn[i]    <= '0;
                r_queued[i] <= 1'b0;
            end
        end else begin
            if (i_ctrl.set_en) begin
                r_static[i_idx] <= i_prio;
                r_dyn[i_idx]    <= i_prio;
            end
            if (i_ctrl.enq_en) begin
                r_queued[i_idx] <= 1'b1;
            end
            if (i_ctrl.pick_en) begin
                r_dyn[i_pick_idx]    <= r_static[i_pick_idx];
                r_queued[i_pick_idx] <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/priority_aging_task_scheduler_top.sv =====
// Top level of the priority aging task scheduler: control, result register, checks.
//
// Every transaction (set priority, enqueue, pick) passes an evaluate and a commit
// state: in the first, every queue cell compares its dynamic priority with all
// other occupied cells in parallel and registers a win flag; in the second, a pick
// shifts out the winner and ages the rest, else a cell is loaded or set, and the
// per-task table is updated. The result is held in an output register, and the next
// transaction is accepted in the commit cycle while the result side keeps up.
module priority_aging_task_scheduler_top import pats_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_cmd               i_command,
    input  t_task              i_task_index,
    input  t_prio              i_priority_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_picked_valid,
    output t_task              o_picked_task,
    output logic               o_error,
    output logic [COUNT_W-1:0] o_ready_count
);

    localparam int LEN_W       = $clog2(MAX_TASKS + 1);
    localparam int TABLE_DEPTH = (MAX_TASKS < TASK_SPAN) ? MAX_TASKS : TASK_SPAN;
    localparam int TIDX_W      = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EVAL   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    t_task              r_task;
    t_prio              r_req;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_out_valid;
    logic               r_picked_valid, n_picked_valid;
    t_task              r_picked_task, n_picked_task;
    logic               r_error, n_error;
    logic [COUNT_W-1:0] r_ready_count;

    logic               w_in_acc;
    logic               w_commit;
    logic               w_task_ok;
    logic               w_lo, w_hi;
    t_prio              w_prio_cl;
    logic [TIDX_W-1:0]  w_tidx;
    logic               w_full;
    logic               w_enq_ok;
    logic               w_pick_ok;
    t_prio              w_tab_dyn;
    logic               w_tab_queued;
    logic [MAX_TASKS-1:0] w_win;
    t_task              w_win_task;
    t_queue_ctrl        w_qctrl;
    t_table_ctrl        w_tctrl;
    t_prio              w_load_prio;

    assign w_commit   = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE) || w_commit;
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_task_ok = int'(r_task) < MAX_TASKS;
    assign w_lo      = r_req < PRIO_MIN;
    assign w_hi      = r_req > PRIO_MAX;
    assign w_prio_cl = w_lo ? PRIO_MIN : (w_hi ? PRIO_MAX : r_req);
    assign w_tidx    = r_task[TIDX_W-1:0];
    assign w_full    = int'(r_len) >= MAX_TASKS;
    assign w_enq_ok  = w_task_ok && !w_tab_queued && !w_full;
    assign w_pick_ok = r_len != '0;

    always_comb begin
        n_len          = r_len;
        n_picked_valid = 1'b0;
        n_picked_task  = '0;
        n_error        = 1'b0;
        w_qctrl        = '0;
        w_tctrl        = '0;
        w_load_prio    = w_prio_cl;
        w_qctrl.eval   = (r_state == S_EVAL);
        case (r_cmd)
            CMD_SET_PRIO: begin
                n_error        = !w_task_ok || w_lo || w_hi;
                w_tctrl.set_en = w_commit && w_task_ok;
                w_qctrl.set    = w_commit && w_task_ok;
            end
            CMD_ENQUEUE: begin
                n_error        = !w_enq_ok;
                w_load_prio    = w_tab_dyn;
                w_tctrl.enq_en = w_commit && w_enq_ok;
                w_qctrl.load   = w_commit && w_enq_ok;
                if (w_enq_ok) begin
                    n_len = r_len + LEN_W'(1);
                end
            end
            CMD_PICK: begin
                if (w_pick_ok) begin
                    n_picked_valid  = 1'b1;
                    n_picked_task   = w_win_task;
                    n_len           = r_len - LEN_W'(1);
                    w_tctrl.pick_en = w_commit;
                    w_qctrl.pick    = w_commit;
                    w_qctrl.age     = r_len > LEN_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (w_in_acc) begin
                    n_state = S_EVAL;
                end else if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd  <= i_command;
            r_task <= i_task_index;
            r_req  <= i_priority_req;
        end
        if (w_commit) begin
            r_picked_valid <= n_picked_valid;
            r_picked_task  <= n_picked_task;
            r_error        <= n_error;
            r_ready_count  <= COUNT_W'(n_len);
        end
    end

    pats_task_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (TIDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_tctrl),
        .i_idx      (w_tidx),
        .i_prio     (w_prio_cl),
        .i_pick_idx (w_win_task[TIDX_W-1:0]),
        .o_dyn      (w_tab_dyn),
        .o_queued   (w_tab_queued)
    );

    pats_queue #(
        .N     (MAX_TASKS),
        .LEN_W (LEN_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_qctrl),
        .i_len      (r_len),
        .i_task     (r_task),
        .i_prio     (w_load_prio),
        .o_win      (w_win),
        .o_win_task (w_win_task)
    );

    assign o_out_valid    = r_out_valid;
    assign o_picked_valid = r_picked_valid;
    assign o_picked_task  = r_picked_task;
    assign o_error        = r_error;
    assign o_ready_count  = r_ready_count;

    a_win_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_cmd == CMD_PICK && r_len != '0) |-> $onehot(w_win))
        else $error("pick winner is not unique");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_len) <= MAX_TASKS)
        else $error("queue length above capacity");

    a_pick_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_cmd == CMD_PICK && r_len != '0) |=> (r_len == $past(r_len) - LEN_W'(1)))
        else $error("pick did not remove one task");

    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid)
        else $error("committed transaction produced no result");

endmodule

// ===== tb/tb_priority_aging_task_scheduler_top.sv =====
// Self-checking testbench for the priority aging task scheduler top level.
module tb_priority_aging_task_scheduler_top import pats_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int   MAX_TASKS    = MAX_TASKS_DEF;
    localparam int   LIMIT_CYCLES = 400_000;
    localparam int   RAND_PHASES  = 35;
    localparam int   PHASE_ITEMS  = 50;
    localparam int   QUIET_PHASES = 4;
    localparam int   N_DIRECTED   = 25;
    localparam t_cmd CMD_UNUSED   = 2'd3;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    typedef struct packed {
        logic               picked_valid;
        t_task              picked_task;
        logic               error;
        logic [COUNT_W-1:0] ready_count;
    } t_outcome;

    // typed = 1: the want_* columns are the expected result, else the predictor decides
    typedef struct packed {
        t_cmd               cmd;
        t_task              tsk;
        t_prio              prio;
        logic               typed;
        logic               want_valid;
        t_task              want_task;
        logic               want_err;
        logic [COUNT_W-1:0] want_count;
    } t_row;

    localparam t_row DIRECTED [0:N_DIRECTED-1] = '{
        '{CMD_PICK,     4'd0,  6'sd0,       1'b1, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_SET_PRIO, 4'd0,  6'sb100000,  1'b1, 1'b0, 4'd0, 1'b1, 5'd0},
        '{CMD_SET_PRIO, 4'd1,  6'sd31,      1'b1, 1'b0, 4'd0, 1'b1, 5'd0},
        '{CMD_SET_PRIO, 4'd2,  -6'sd21,     1'b1, 1'b0, 4'd0, 1'b1, 5'd0},
        '{CMD_SET_PRIO, 4'd3,  6'sd21,      1'b1, 1'b0, 4'd0, 1'b1, 5'd0},
        '{CMD_SET_PRIO, 4'd4,  -6'sd20,     1'b1, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_SET_PRIO, 4'd5,  6'sd20,      1'b1, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_UNUSED,   4'd15, -6'sd1,      1'b1, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_ENQUEUE,  4'd5,  6'sd0,       1'b1, 1'b0, 4'd0, 1'b0, 5'd1},
        '{CMD_ENQUEUE,  4'd5,  6'sd0,       1'b1, 1'b0, 4'd0, 1'b1, 5'd1},
        '{CMD_PICK,     4'd0,  6'sd0,       1'b1, 1'b1, 4'd5, 1'b0, 5'd0},
        '{CMD_ENQUEUE,  4'd15, 6'sd0,       1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_ENQUEUE,  4'd0,  6'sd0,       1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_ENQUEUE,  4'd1,  6'sd0,       1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_ENQUEUE,  4'd4,  6'sd0,       1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_PICK,     4'd15, 6'sd31,      1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_SET_PRIO, 4'd15, -6'sd1,      1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_ENQUEUE,  4'd2,  6'sd0,       1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_PICK,     4'd0,  6'sd0,       1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_PICK,     4'd0,  6'sd0,       1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_PICK,     4'd0,  6'sd0,       1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_PICK,     4'd0,  6'sd0,       1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_PICK,     4'd0,  6'sd0,       1'b1, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_ENQUEUE,  4'd15, 6'sb100000,  1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{CMD_UNUSED,   4'd0,  6'sd31,      1'b1, 1'b0, 4'd0, 1'b0, 5'd1}
    };

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    t_cmd               i_command      = CMD_SET_PRIO;
    t_task              i_task_index   = '0;
    t_prio              i_priority_req = '0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b1;
    logic               o_picked_valid;
    t_task              o_picked_task;
    logic               o_error;
    logic [COUNT_W-1:0] o_ready_count;

    // scheduler state as predicted
    int       ready_list[$];
    t_prio    base_prio [MAX_TASKS];
    t_prio    eff_prio  [MAX_TASKS];
    bit       in_list   [MAX_TASKS];

    t_outcome pending_outcomes[$];
    t_outcome want;
    t_outcome got;
    int       mismatch_cnt = 0;
    int       cycle_cnt    = 0;
    bit       in_gaps_on   = 1'b1;
    logic     stall_on     = 1'b0;
    int       stall_cnt    = 0;

    priority_aging_task_scheduler_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_task_index   (i_task_index),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_picked_valid (o_picked_valid),
        .o_picked_task  (o_picked_task),
        .o_error        (o_error),
        .o_ready_count  (o_ready_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_outcome schedule_step(input t_cmd c, input t_task tsk, input t_prio p);
        t_outcome r;
        int       best;
        int       chosen;
        r = '0;
        case (c)
            CMD_SET_PRIO: begin
                if (p < PRIO_MIN) begin
                    base_prio[tsk] = PRIO_MIN;
                    r.error = 1'b1;
                end else if (p > PRIO_MAX) begin
                    base_prio[tsk] = PRIO_MAX;
                    r.error = 1'b1;
                end else begin
                    base_prio[tsk] = p;
                end
                eff_prio[tsk] = base_prio[tsk];
            end
            CMD_ENQUEUE: begin
                if (in_list[tsk] || ready_list.size() >= MAX_TASKS) begin
                    r.error = 1'b1;
                end else begin
                    ready_list.push_back(int'(tsk));
                    in_list[tsk] = 1'b1;
                end
            end
            CMD_PICK: begin
                if (ready_list.size() > 0) begin
                    best = 0;
                    for (int i = 1; i < ready_list.size(); i++) begin
                        if (eff_prio[ready_list[i]] < eff_prio[ready_list[best]])
                            best = i;
                    end
                    chosen = ready_list[best];
                    if (ready_list.size() > 1) begin
                        foreach (ready_list[i]) begin
                            if (eff_prio[ready_list[i]] > PRIO_MIN)
                                eff_prio[ready_list[i]] = eff_prio[ready_list[i]] - 6'sd1;
                        end
                    end
                    eff_prio[chosen] = base_prio[chosen];
                    in_list[chosen] = 1'b0;
                    ready_list.delete(best);
                    r.picked_valid = 1'b1;
                    r.picked_task = t_task'(chosen);
                end
            end
            default: ;
        endcase
        r.ready_count = COUNT_W'(ready_list.size());
        return r;
    endfunction

    // valid stays high back to back unless a gap is drawn
    task automatic send_txn(input t_cmd c, input t_task tsk, input t_prio p,
                            input logic typed, input t_outcome typed_want);
        int       gap;
        t_outcome r;
        if (in_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= c;
        i_task_index   <= tsk;
        i_priority_req <= p;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = schedule_step(c, tsk, p);
        pending_outcomes.push_back(typed ? typed_want : r);
    endtask

    always @(posedge i_clk) begin
        if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
        end else if (stall_on && $urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            stall_cnt   <= $urandom_range(0, 15);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_picked_valid, o_picked_task, o_error, o_ready_count};
            if (pending_outcomes.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected transaction: valid=%0d task=%0d err=%0d count=%0d",
                             got.picked_valid, got.picked_task, got.error, got.ready_count);
            end else begin
                want = pending_outcomes.pop_front();
                if (want !== got) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"mismatch: valid exp %0d act %0d, task exp %0d act %0d, ",
                                  "err exp %0d act %0d, count exp %0d act %0d"},
                                 want.picked_valid, got.picked_valid,
                                 want.picked_task, got.picked_task,
                                 want.error, got.error, want.ready_count, got.ready_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_row     row;
        t_mix     mix;
        int       roll;
        bit       quiet;
        t_cmd     c;
        t_task    tsk;
        t_prio    pr;
        t_task    free_list[$];

        foreach (base_prio[i]) begin
            base_prio[i] = '0;
            eff_prio[i]  = '0;
            in_list[i]   = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < N_DIRECTED; n++) begin
            row = DIRECTED[n];
            send_txn(row.cmd, row.tsk, row.prio, row.typed,
                     '{row.want_valid, row.want_task, row.want_err, row.want_count});
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            mix        = t_mix'($urandom_range(0, 2));
            quiet      = (ph >= RAND_PHASES - QUIET_PHASES);
            in_gaps_on = !quiet && $urandom_range(0, 2) != 0;
            stall_on  <= !quiet && $urandom_range(0, 2) != 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL:  c = roll < 60 ? CMD_ENQUEUE : roll < 80 ? CMD_SET_PRIO :
                                   roll < 97 ? CMD_PICK : CMD_UNUSED;
                    MIX_DRAIN: c = roll < 60 ? CMD_PICK : roll < 80 ? CMD_ENQUEUE :
                                   roll < 97 ? CMD_SET_PRIO : CMD_UNUSED;
                    default:   c = roll < 33 ? CMD_ENQUEUE : roll < 66 ? CMD_PICK :
                                   roll < 97 ? CMD_SET_PRIO : CMD_UNUSED;
                endcase
                // enqueue mostly targets tasks not yet queued so the queue can fill up
                free_list.delete();
                foreach (in_list[i])
                    if (!in_list[i]) free_list.push_back(t_task'(i));
                if (c == CMD_ENQUEUE && free_list.size() != 0 && $urandom_range(0, 3) != 0)
                    tsk = free_list[$urandom_range(0, free_list.size() - 1)];
                else
                    tsk = t_task'($urandom_range(0, MAX_TASKS - 1));
                if ($urandom_range(0, 4) != 0)
                    pr = t_prio'(int'($urandom_range(0, 40)) - 20);
                else
                    pr = t_prio'($urandom_range(0, 63));
                send_txn(c, tsk, pr, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
